// ===== design/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Invariant checked at every clock edge outside reset.
`define ASSERT_ALWAYS(label, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("invariant violated");

// Same-cycle implication.
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication violated");

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle implication violated");

`endif

// ===== design/rss_pkg.sv =====
`default_nettype none

package rss_pkg;

  localparam int KEY_W  = 16;
  localparam int ID_W   = 32;
  localparam int TAG_W  = 5;
  localparam int RANK_W = 6;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [ID_W-1:0]  id;
    logic [TAG_W-1:0] tag;
  } rec_t;

  typedef enum logic [2:0] {
    S_LOAD,
    S_SCAN,
    S_SWAP_I,
    S_SWAP_B,
    S_NEXT,
    S_EMIT_RD,
    S_EMIT_OUT
  } state_t;

endpackage

`default_nettype wire

// ===== design/rss_in_if.sv =====
`default_nettype none

interface rss_in_if import rss_pkg::*;;
  logic              valid;
  logic              ready;
  logic [KEY_W-1:0]  score_total;
  logic [ID_W-1:0]   student_id;
  logic [TAG_W-1:0]  row_tag;
  logic              last_record;

  modport source (output valid, score_total, student_id, row_tag, last_record,
                  input ready);
  modport sink   (input valid, score_total, student_id, row_tag, last_record,
                  output ready);
endinterface

`default_nettype wire

// ===== design/rss_out_if.sv =====
`default_nettype none

interface rss_out_if import rss_pkg::*;;
  logic              valid;
  logic              ready;
  logic [KEY_W-1:0]  sorted_total;
  logic [ID_W-1:0]   sorted_id;
  logic [TAG_W-1:0]  sorted_tag;
  logic [RANK_W-1:0] rank;
  logic              dropped_flag;
  logic              final_result;

  modport source (output valid, sorted_total, sorted_id, sorted_tag, rank, dropped_flag,
                  final_result, input ready);
  modport sink   (input valid, sorted_total, sorted_id, sorted_tag, rank, dropped_flag,
                  final_result, output ready);
endinterface

`default_nettype wire

// ===== design/rss_ram.sv =====
`default_nettype none

module rss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== design/record_selection_sort_by_key_top.sv =====
// Loading: one record transfer per cycle; the set closes on the record marked last.
// Sorting n >= 2 records: pass i reads rows i..n-1, drains the last compare, decides, makes
// the two swap writes when needed and starts the next pass. A one-record set skips the sort.
// Emitting: each result is a RAM read, then the output transfer, which waits out receiver stalls.
// Synchronous reset (rst_n low) empties the set and selects descending; the RAM is kept.
`default_nettype none

module record_selection_sort_by_key_top import rss_pkg::*; #(
  parameter int MAX_RECORDS = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data,
  rss_in_if.sink     in_ch,
  rss_out_if.source  out_ch
);

  `include "assert_macros.svh"

  localparam int AW  = $clog2(MAX_RECORDS);
  localparam int CW  = $clog2(MAX_RECORDS + 1);
  localparam int REC_W = $bits(rec_t);

  state_t         state_r, state_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic           ovf_r, ovf_nxt;
  logic           dir_r;
  logic [AW-1:0]  pass_r, pass_nxt;
  logic [CW-1:0]  rd_idx_r, rd_idx_nxt;
  logic           cmp_vld_r, cmp_vld_nxt;
  logic [AW-1:0]  cmp_idx_r, cmp_idx_nxt;
  logic [AW-1:0]  best_idx_r, best_idx_nxt;
  rec_t           best_row_r, best_row_nxt;
  rec_t           row_i_r, row_i_nxt;
  logic [CW-1:0]  k_r, k_nxt;

  logic           in_fire, out_fire;
  logic           store_ok, rd_done, better, is_final;
  logic [CW-1:0]  n_load, k_p1;
  rec_t           in_rec, rd_rec;

  logic           ram_we, ram_re;
  logic [AW-1:0]  ram_waddr, ram_raddr;
  rec_t           ram_wdata;
  logic [REC_W-1:0] ram_rdata;

  rss_ram #(.WIDTH(REC_W), .DEPTH(MAX_RECORDS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_rec    = rec_t'(ram_rdata);
  assign in_rec    = '{key: in_ch.score_total, id: in_ch.student_id, tag: in_ch.row_tag};
  assign in_fire   = in_ch.valid && in_ch.ready;
  assign out_fire  = out_ch.valid && out_ch.ready;
  assign store_ok  = cnt_r < CW'(MAX_RECORDS);
  assign n_load    = store_ok ? cnt_r + CW'(1) : cnt_r;
  assign rd_done   = rd_idx_r == cnt_r;
  assign better    = dir_r ? (rd_rec.key < best_row_r.key) : (rd_rec.key > best_row_r.key);
  assign k_p1      = k_r + CW'(1);
  assign is_final  = k_p1 == cnt_r;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_LOAD: begin
        if (in_fire && in_ch.last_record) begin
          state_nxt = (n_load < CW'(2)) ? S_EMIT_RD : S_SCAN;
        end
      end
      S_SCAN: begin
        if (rd_done && !cmp_vld_r) begin
          state_nxt = (best_idx_r == pass_r) ? S_NEXT : S_SWAP_I;
        end
      end
      S_SWAP_I: state_nxt = S_SWAP_B;
      S_SWAP_B: state_nxt = S_NEXT;
      S_NEXT: begin
        // The next pass exists only while two or more unsorted rows remain.
        state_nxt = (CW'(pass_r) + CW'(2) >= cnt_r) ? S_EMIT_RD : S_SCAN;
      end
      S_EMIT_RD: state_nxt = S_EMIT_OUT;
      S_EMIT_OUT: begin
        if (out_fire) begin
          state_nxt = is_final ? S_LOAD : S_EMIT_RD;
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  // State-decoded outputs and RAM access.
  always_comb begin
    in_ch.ready  = 1'b0;
    out_ch.valid = 1'b0;
    ram_we       = 1'b0;
    ram_waddr    = cnt_r[AW-1:0];
    ram_wdata    = in_rec;
    ram_re       = 1'b0;
    ram_raddr    = rd_idx_r[AW-1:0];
    unique case (state_r)
      S_LOAD: begin
        in_ch.ready = 1'b1;
        ram_we      = in_fire && store_ok;
      end
      S_SCAN: begin
        ram_re = !rd_done;
      end
      S_SWAP_I: begin
        ram_we    = 1'b1;
        ram_waddr = pass_r;
        ram_wdata = best_row_r;
      end
      S_SWAP_B: begin
        ram_we    = 1'b1;
        ram_waddr = best_idx_r;
        ram_wdata = row_i_r;
      end
      S_NEXT: begin
      end
      S_EMIT_RD: begin
        ram_re    = 1'b1;
        ram_raddr = k_r[AW-1:0];
      end
      S_EMIT_OUT: begin
        out_ch.valid = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // The RAM read register holds the row until the next read, so it serves as payload.
  assign out_ch.sorted_total = rd_rec.key;
  assign out_ch.sorted_id    = rd_rec.id;
  assign out_ch.sorted_tag   = rd_rec.tag;
  assign out_ch.rank         = RANK_W'(k_p1);
  assign out_ch.dropped_flag = ovf_r;
  assign out_ch.final_result = is_final;

  // Datapath next values.
  always_comb begin
    cnt_nxt      = cnt_r;
    ovf_nxt      = ovf_r;
    pass_nxt     = pass_r;
    rd_idx_nxt   = rd_idx_r;
    cmp_vld_nxt  = cmp_vld_r;
    cmp_idx_nxt  = cmp_idx_r;
    best_idx_nxt = best_idx_r;
    best_row_nxt = best_row_r;
    row_i_nxt    = row_i_r;
    k_nxt        = k_r;
    unique case (state_r)
      S_LOAD: begin
        if (in_fire) begin
          if (store_ok) begin
            cnt_nxt = cnt_r + CW'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_ch.last_record) begin
            pass_nxt    = '0;
            rd_idx_nxt  = '0;
            cmp_vld_nxt = 1'b0;
            k_nxt       = '0;
          end
        end
      end
      S_SCAN: begin
        cmp_vld_nxt = !rd_done;
        cmp_idx_nxt = rd_idx_r[AW-1:0];
        if (!rd_done) begin
          rd_idx_nxt = rd_idx_r + CW'(1);
        end
        if (cmp_vld_r) begin
          // The first row of a pass seeds the best and is kept for the swap.
          if (cmp_idx_r == pass_r) begin
            best_row_nxt = rd_rec;
            best_idx_nxt = pass_r;
            row_i_nxt    = rd_rec;
          end else if (better) begin
            best_row_nxt = rd_rec;
            best_idx_nxt = cmp_idx_r;
          end
        end
      end
      S_SWAP_I, S_SWAP_B: begin
      end
      S_NEXT: begin
        pass_nxt    = pass_r + AW'(1);
        rd_idx_nxt  = CW'(pass_r) + CW'(1);
        cmp_vld_nxt = 1'b0;
        k_nxt       = '0;
      end
      S_EMIT_RD: begin
      end
      S_EMIT_OUT: begin
        if (out_fire) begin
          if (is_final) begin
            cnt_nxt = '0;
            ovf_nxt = 1'b0;
          end else begin
            k_nxt = k_p1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_LOAD;
      cnt_r      <= '0;
      ovf_r      <= 1'b0;
      dir_r      <= 1'b0;
      pass_r     <= '0;
      rd_idx_r   <= '0;
      cmp_vld_r  <= 1'b0;
      cmp_idx_r  <= '0;
      best_idx_r <= '0;
      k_r        <= '0;
    end else begin
      state_r    <= state_nxt;
      cnt_r      <= cnt_nxt;
      ovf_r      <= ovf_nxt;
      pass_r     <= pass_nxt;
      rd_idx_r   <= rd_idx_nxt;
      cmp_vld_r  <= cmp_vld_nxt;
      cmp_idx_r  <= cmp_idx_nxt;
      best_idx_r <= best_idx_nxt;
      k_r        <= k_nxt;
      if (cfg_wr_en) begin
        dir_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    best_row_r <= best_row_nxt;
    row_i_r    <= row_i_nxt;
  end

  `ASSERT_ALWAYS(a_cnt_bound, cnt_r <= CW'(MAX_RECORDS))
  `ASSERT_IMPL(a_emit_in_range, out_ch.valid, k_r < cnt_r)
  `ASSERT_IMPL(a_swap_forward, state_r == S_SWAP_B, best_idx_r > pass_r)
  `ASSERT_NEXT(a_set_cleared, out_fire && is_final, state_r == S_LOAD && cnt_r == '0 && !ovf_r)

endmodule

`default_nettype wire

// ===== dv/tb_record_selection_sort_by_key_top.sv =====
`default_nettype none

module tb_record_selection_sort_by_key_top import rss_pkg::*;;

  localparam int MAX_RECORDS   = 32;
  localparam int RANDOM_ITEMS  = 80;
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int MAX_PRINTED   = 50;

  typedef struct packed {
    logic [KEY_W-1:0]  total;
    logic [ID_W-1:0]   id;
    logic [TAG_W-1:0]  tag;
    logic [RANK_W-1:0] rank;
    logic              dropped;
    logic              is_last;
  } ranked_t;

  typedef struct {
    logic    set_dir;
    logic    dir;
    rec_t    rec;
    logic    last;
    logic    typed;
    ranked_t want;
  } stim_row_t;

  logic clk;
  logic rst_n;
  logic cfg_wr_en;
  logic cfg_wr_data;

  rss_in_if  in_ch ();
  rss_out_if out_ch ();

  record_selection_sort_by_key_top #(
    .MAX_RECORDS (MAX_RECORDS)
  ) i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_ch       (in_ch),
    .out_ch      (out_ch)
  );

  // Shadow of the record store, the set bookkeeping and the direction register.
  rec_t        held_rec [MAX_RECORDS];
  int unsigned held_count;
  logic        held_drop;
  logic        sort_dir;

  ranked_t     ranked_q [$];
  int unsigned error_count;
  int unsigned burst_left;
  int unsigned cycle_count = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic report_error(input string msg);
    error_count++;
    if (error_count <= MAX_PRINTED) begin
      $display("ERROR at %0t: %s", $time, msg);
    end
  endtask

  task automatic check_field(input string name, input logic [ID_W-1:0] got,
                             input logic [ID_W-1:0] want);
    if (got !== want) begin
      report_error($sformatf("%s is %0h, expected %0h", name, got, want));
    end
  endtask

  // Stores one record and, on the closing record, sorts the set and queues the ranked list.
  // Each pass keeps the earliest strictly better key, which fixes the order of ties.
  function automatic void take_record(input rec_t r, input logic last, input logic typed,
                                      input ranked_t want);
    rec_t        tmp;
    int unsigned best;
    ranked_t     res;
    if (held_count < MAX_RECORDS) begin
      held_rec[held_count] = r;
      held_count++;
    end else begin
      held_drop = 1'b1;
    end
    if (!last) begin
      return;
    end
    for (int unsigned i = 0; i + 1 < held_count; i++) begin
      best = i;
      for (int unsigned j = i + 1; j < held_count; j++) begin
        if (sort_dir ? (held_rec[j].key < held_rec[best].key)
                     : (held_rec[j].key > held_rec[best].key)) begin
          best = j;
        end
      end
      tmp            = held_rec[best];
      held_rec[best] = held_rec[i];
      held_rec[i]    = tmp;
    end
    if (typed) begin
      ranked_q.push_back(want);
    end else begin
      for (int unsigned k = 0; k < held_count; k++) begin
        res.total   = held_rec[k].key;
        res.id      = held_rec[k].id;
        res.tag     = held_rec[k].tag;
        res.rank    = RANK_W'(k + 1);
        res.dropped = held_drop;
        res.is_last = (k + 1 == held_count);
        ranked_q.push_back(res);
      end
    end
    held_count = 0;
    held_drop  = 1'b0;
  endfunction

  function automatic stim_row_t stim_row(input logic set_dir, input logic dir, input rec_t rec,
                                         input logic last, input logic typed,
                                         input ranked_t want);
    stim_row_t row;
    row.set_dir = set_dir;
    row.dir     = dir;
    row.rec     = rec;
    row.last    = last;
    row.typed   = typed;
    row.want    = want;
    return row;
  endfunction

  // The sender works in bursts; a burst starts after a random gap, sometimes none.
  task automatic send_record(input rec_t r, input logic last, input logic typed,
                             input ranked_t want);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_ch.valid       <= 1'b1;
    in_ch.score_total <= r.key;
    in_ch.student_id  <= r.id;
    in_ch.row_tag     <= r.tag;
    in_ch.last_record <= last;
    do @(posedge clk); while (!in_ch.ready);
    take_record(r, last, typed, want);
  endtask

  // Waits until every queued result has been transferred and the block has gone quiet.
  task automatic settle();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    while (ranked_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_direction(input logic dir);
    settle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= dir;
    @(posedge clk);
    sort_dir = dir;
    cfg_wr_en <= 1'b0;
  endtask

  always @(posedge clk) begin : result_check
    ranked_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (ranked_q.size() == 0) begin
        report_error("result transfer with no result expected");
      end else begin
        want = ranked_q.pop_front();
        check_field("sorted_total", ID_W'(out_ch.sorted_total), ID_W'(want.total));
        check_field("sorted_id", out_ch.sorted_id, want.id);
        check_field("sorted_tag", ID_W'(out_ch.sorted_tag), ID_W'(want.tag));
        check_field("rank", ID_W'(out_ch.rank), ID_W'(want.rank));
        check_field("dropped_flag", ID_W'(out_ch.dropped_flag), ID_W'(want.dropped));
        check_field("final_result", ID_W'(out_ch.final_result), ID_W'(want.is_last));
      end
    end
  end

  // The receiver picks a new behaviour for each random span: always ready, random stalls,
  // toggling, or a solid stall.
  initial begin : receiver
    int unsigned mode;
    int unsigned span;
    out_ch.ready = 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(4, 40);
      repeat (span) begin
        @(posedge clk);
        case (mode)
          0: begin
            out_ch.ready <= 1'b1;
          end
          1: begin
            out_ch.ready <= ($urandom_range(0, 3) != 0);
          end
          2: begin
            out_ch.ready <= ~out_ch.ready;
          end
          default: begin
            out_ch.ready <= 1'b0;
          end
        endcase
      end
    end
  end

  initial begin : stimulus
    stim_row_t   rows [$];
    rec_t        r;
    int unsigned items;
    int unsigned set_idx;
    int unsigned set_len;
    int unsigned pick;

    rst_n             = 1'b0;
    cfg_wr_en         = 1'b0;
    cfg_wr_data       = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.score_total = '0;
    in_ch.student_id  = '0;
    in_ch.row_tag     = '0;
    in_ch.last_record = 1'b0;
    held_count        = 0;
    held_drop         = 1'b0;
    sort_dir          = 1'b0;
    burst_left        = 0;
    error_count       = 0;

    // Single-record sets carry their expected result in the table; the rest go to the
    // predictor. Tie groups check that equal keys keep the selection order.
    rows.push_back(stim_row(1'b1, 1'b0, {16'hFFFF, 32'hFFFF_FFFF, 5'd31}, 1'b1, 1'b1,
                            {16'hFFFF, 32'hFFFF_FFFF, 5'd31, 6'd1, 1'b0, 1'b1}));
    rows.push_back(stim_row(1'b0, 1'b0, {16'h0000, 32'h0000_0000, 5'd0}, 1'b1, 1'b1,
                            {16'h0000, 32'h0000_0000, 5'd0, 6'd1, 1'b0, 1'b1}));
    rows.push_back(stim_row(1'b0, 1'b0, {16'd100, 32'd11, 5'd1}, 1'b0, 1'b0, '0));
    rows.push_back(stim_row(1'b0, 1'b0, {16'd200, 32'd12, 5'd2}, 1'b0, 1'b0, '0));
    rows.push_back(stim_row(1'b0, 1'b0, {16'd100, 32'd13, 5'd3}, 1'b0, 1'b0, '0));
    rows.push_back(stim_row(1'b0, 1'b0, {16'd200, 32'd14, 5'd4}, 1'b0, 1'b0, '0));
    rows.push_back(stim_row(1'b0, 1'b0, {16'd50, 32'd15, 5'd5}, 1'b1, 1'b0, '0));
    rows.push_back(stim_row(1'b1, 1'b1, {16'h8000, 32'h5555_AAAA, 5'd21}, 1'b1, 1'b1,
                            {16'h8000, 32'h5555_AAAA, 5'd21, 6'd1, 1'b0, 1'b1}));
    rows.push_back(stim_row(1'b0, 1'b1, {16'd300, 32'd21, 5'd6}, 1'b0, 1'b0, '0));
    rows.push_back(stim_row(1'b0, 1'b1, {16'd300, 32'd22, 5'd7}, 1'b0, 1'b0, '0));
    rows.push_back(stim_row(1'b0, 1'b1, {16'd10, 32'd23, 5'd8}, 1'b0, 1'b0, '0));
    rows.push_back(stim_row(1'b0, 1'b1, {16'd300, 32'd24, 5'd9}, 1'b0, 1'b0, '0));
    rows.push_back(stim_row(1'b0, 1'b1, {16'd10, 32'd25, 5'd10}, 1'b0, 1'b0, '0));
    rows.push_back(stim_row(1'b0, 1'b1, {16'hFFFF, 32'd26, 5'd11}, 1'b1, 1'b0, '0));
    rows.push_back(stim_row(1'b0, 1'b1, {16'd777, 32'd31, 5'd12}, 1'b0, 1'b0, '0));
    rows.push_back(stim_row(1'b0, 1'b1, {16'd777, 32'd32, 5'd13}, 1'b0, 1'b0, '0));
    rows.push_back(stim_row(1'b0, 1'b1, {16'd777, 32'd33, 5'd14}, 1'b1, 1'b0, '0));

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) begin
      if (rows[i].set_dir) begin
        write_direction(rows[i].dir);
      end
      send_record(rows[i].rec, rows[i].last, rows[i].typed, rows[i].want);
    end

    // The first random set overflows the store with its closing record among the dropped,
    // the second fills it exactly; the rest are mostly small sets with many tied keys.
    items   = 0;
    set_idx = 0;
    while (items < RANDOM_ITEMS) begin
      if (set_idx == 0) begin
        set_len = MAX_RECORDS + $urandom_range(1, 3);
      end else if (set_idx == 1) begin
        set_len = MAX_RECORDS;
      end else begin
        pick = $urandom_range(0, 9);
        if (pick < 7) begin
          set_len = $urandom_range(1, 6);
        end else if (pick < 9) begin
          set_len = $urandom_range(7, MAX_RECORDS - 1);
        end else begin
          set_len = $urandom_range(MAX_RECORDS, MAX_RECORDS + 4);
        end
      end
      if (set_idx < 2 || $urandom_range(0, 2) == 0) begin
        write_direction(1'($urandom_range(0, 1)));
      end
      for (int unsigned k = 0; k < set_len; k++) begin
        r.key = ($urandom_range(0, 1) == 0) ? KEY_W'($urandom_range(0, 7)) : KEY_W'($urandom);
        r.id  = $urandom;
        r.tag = TAG_W'($urandom_range(0, 31));
        send_record(r, k + 1 == set_len, 1'b0, '0);
      end
      items += set_len;
      set_idx++;
    end

    settle();
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire
